### sv/ghg_pkg.sv
// ghg_pkg: shared types, field widths, register codes and reset values of the
// gradient histogram grid. No dependencies.
`default_nettype none

package ghg_pkg;

  // default geometry
  localparam int IMAGE_WIDTH_DEF  = 32;
  localparam int IMAGE_HEIGHT_DEF = 32;
  localparam int GRID_ROWS_DEF    = 4;
  localparam int GRID_COLS_DEF    = 4;

  // classes and bins
  localparam int DIR_CLASSES     = 3;
  localparam int MAG_CLASSES     = 5;
  localparam int BINS_PER_REGION = DIR_CLASSES * DIR_CLASSES * MAG_CLASSES;

  // field widths
  localparam int PIXEL_W     = 8;
  localparam int REGION_W    = 4;
  localparam int BIN_W       = 6;
  localparam int COUNT_W     = 11;
  localparam int THRESH_W    = 8;
  localparam int EDGE_W      = 9;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 9;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // item kinds
  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_READ  = 1'b1;

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_DIR_THRESHOLD = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_EDGE_ONE      = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_EDGE_TWO      = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_EDGE_THREE    = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_EDGE_FOUR     = 3'd4;

  // register reset values
  localparam logic [THRESH_W-1:0] DIR_THRESHOLD_RST = 8'd10;
  localparam logic [EDGE_W-1:0]   EDGE_ONE_RST      = 9'd5;
  localparam logic [EDGE_W-1:0]   EDGE_TWO_RST      = 9'd20;
  localparam logic [EDGE_W-1:0]   EDGE_THREE_RST    = 9'd50;
  localparam logic [EDGE_W-1:0]   EDGE_FOUR_RST     = 9'd100;

  typedef struct packed {
    logic [THRESH_W-1:0] dir_threshold;
    logic [EDGE_W-1:0]   edge_one;
    logic [EDGE_W-1:0]   edge_two;
    logic [EDGE_W-1:0]   edge_three;
    logic [EDGE_W-1:0]   edge_four;
  } cfg_t;

  // signed pixel difference, -255..255
  typedef logic signed [PIXEL_W:0] diff_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ROW,
    ST_JOB,
    ST_HRD,
    ST_HWR
  } state_t;

  // the up to three tallies one pixel can cause
  typedef enum logic [1:0] {
    JOB_ABOVE,
    JOB_LEFT,
    JOB_CORNER
  } job_t;

endpackage

`default_nettype wire

### sv/ghg_ram.sv
// ghg_ram: generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`default_nettype none

module ghg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### sv/ghg_classify.sv
// ghg_classify: sorts a gradient pair into its bin (direction classes of gx and
// gy, magnitude class of |gx|+|gy|). Depends on ghg_pkg.
`default_nettype none

module ghg_classify (
  input  wire ghg_pkg::cfg_t              cfg,
  input  wire ghg_pkg::diff_t             gx,
  input  wire ghg_pkg::diff_t             gy,
  output logic [ghg_pkg::BIN_W-1:0]       bin
);

  import ghg_pkg::*;

  localparam logic [BIN_W-1:0] DIR_STRIDE = BIN_W'(DIR_CLASSES * MAG_CLASSES);
  localparam logic [BIN_W-1:0] MAG_STRIDE = BIN_W'(MAG_CLASSES);

  logic signed [PIXEL_W+1:0] thr_pos;
  logic signed [PIXEL_W+1:0] thr_neg;
  logic signed [PIXEL_W+1:0] gx_e;
  logic signed [PIXEL_W+1:0] gy_e;
  logic [1:0]                dx;
  logic [1:0]                dy;
  logic [PIXEL_W-1:0]        ax;
  logic [PIXEL_W-1:0]        ay;
  logic [EDGE_W-1:0]         mag;
  logic [2:0]                mcls;

  always_comb begin
    thr_pos = $signed({2'b00, cfg.dir_threshold});
    thr_neg = -thr_pos;
    gx_e    = {gx[PIXEL_W], gx};
    gy_e    = {gy[PIXEL_W], gy};

    if (gx_e > thr_pos) begin
      dx = 2'd2;
    end else if (gx_e < thr_neg) begin
      dx = 2'd0;
    end else begin
      dx = 2'd1;
    end

    if (gy_e > thr_pos) begin
      dy = 2'd2;
    end else if (gy_e < thr_neg) begin
      dy = 2'd0;
    end else begin
      dy = 2'd1;
    end

    ax  = gx[PIXEL_W] ? PIXEL_W'(-gx) : gx[PIXEL_W-1:0];
    ay  = gy[PIXEL_W] ? PIXEL_W'(-gy) : gy[PIXEL_W-1:0];
    mag = {1'b0, ax} + {1'b0, ay};

    // edges tested in order, so a non-increasing edge leaves its class empty
    if (mag < cfg.edge_one) begin
      mcls = 3'd0;
    end else if (mag < cfg.edge_two) begin
      mcls = 3'd1;
    end else if (mag < cfg.edge_three) begin
      mcls = 3'd2;
    end else if (mag < cfg.edge_four) begin
      mcls = 3'd3;
    end else begin
      mcls = 3'd4;
    end

    bin = BIN_W'(dx) * DIR_STRIDE + BIN_W'(dy) * MAG_STRIDE + BIN_W'(mcls);
  end

endmodule

`default_nettype wire

### sv/gradient_histogram_grid.sv
// gradient_histogram_grid: top level; per-region gradient histograms kept in a
// count RAM with read-modify-write, previous row kept in a row RAM.
// Depends on ghg_pkg, ghg_ram, ghg_classify.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+----------------------------------
//   in      | input     | in_valid/in_stall  | in_kind, in_pixel, in_region, in_bin
//   out     | output    | out_valid/out_stall| out_count
//   cfg     | input     | cfg_we             | cfg_index, cfg_data
//
// One item is worked at a time; the single port pair of the count RAM sets the
// pace. A pixel passes the row state, then for each tally it causes a job step,
// a count read and a count write; a tally it skips takes only the job step. A
// read passes the count read and write states and stays in the write state
// while the previous count is still held in the output register. After reset a
// clearing pass zeroes the count RAM, one entry a cycle (GRID_ROWS*GRID_COLS*45
// entries, 720 by default); items wait, config writes are taken throughout.
`default_nettype none

module gradient_histogram_grid #(
  parameter int IMAGE_WIDTH  = ghg_pkg::IMAGE_WIDTH_DEF,
  parameter int IMAGE_HEIGHT = ghg_pkg::IMAGE_HEIGHT_DEF,
  parameter int GRID_ROWS    = ghg_pkg::GRID_ROWS_DEF,
  parameter int GRID_COLS    = ghg_pkg::GRID_COLS_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic                               in_kind,
  input  wire logic [ghg_pkg::PIXEL_W-1:0]        in_pixel,
  input  wire logic [ghg_pkg::REGION_W-1:0]       in_region,
  input  wire logic [ghg_pkg::BIN_W-1:0]          in_bin,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic [ghg_pkg::COUNT_W-1:0]             out_count,
  input  wire logic                               cfg_we,
  input  wire logic [ghg_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  wire logic [ghg_pkg::CFG_DATA_W-1:0]     cfg_data
);

  import ghg_pkg::*;

  localparam int XW      = $clog2(IMAGE_WIDTH);
  localparam int YW      = $clog2(IMAGE_HEIGHT);
  localparam int RXW     = (GRID_COLS > 1) ? $clog2(GRID_COLS) : 1;
  localparam int RYW     = (GRID_ROWS > 1) ? $clog2(GRID_ROWS) : 1;
  localparam int REGIONS = GRID_ROWS * GRID_COLS;
  localparam int DEPTH   = REGIONS * BINS_PER_REGION;
  localparam int IDX_W   = $clog2(DEPTH);

  localparam logic [XW-1:0]    X_LAST       = XW'(IMAGE_WIDTH - 1);
  localparam logic [YW-1:0]    Y_LAST       = YW'(IMAGE_HEIGHT - 1);
  localparam logic [XW:0]      X_SPAN       = (XW + 1)'(IMAGE_WIDTH);
  localparam logic [YW:0]      Y_SPAN       = (YW + 1)'(IMAGE_HEIGHT);
  // region column advances by GRID_COLS/IMAGE_WIDTH per pixel plus a carry
  localparam logic [RXW-1:0]   RX_WHOLE     = RXW'(GRID_COLS / IMAGE_WIDTH);
  localparam logic [XW:0]      RX_FRAC      = (XW + 1)'(GRID_COLS % IMAGE_WIDTH);
  localparam logic [RYW-1:0]   RY_WHOLE     = RYW'(GRID_ROWS / IMAGE_HEIGHT);
  localparam logic [YW:0]      RY_FRAC      = (YW + 1)'(GRID_ROWS % IMAGE_HEIGHT);
  localparam logic [IDX_W-1:0] IDX_LAST     = IDX_W'(DEPTH - 1);
  localparam logic [IDX_W-1:0] IDX_COLS     = IDX_W'(GRID_COLS);
  localparam logic [IDX_W-1:0] IDX_BINS     = IDX_W'(BINS_PER_REGION);
  localparam logic [8:0]       REGION_LIMIT = 9'(REGIONS);
  localparam logic [BIN_W-1:0] BIN_LIMIT    = BIN_W'(BINS_PER_REGION);

  function automatic diff_t pixel_diff(input logic [PIXEL_W-1:0] a,
                                       input logic [PIXEL_W-1:0] b);
    return $signed({1'b0, a}) - $signed({1'b0, b});
  endfunction

  // registers
  state_t             state_r, state_nxt;
  job_t               jsel_r, jsel_nxt;
  logic [IDX_W-1:0]   clr_cnt_r, clr_cnt_nxt;
  cfg_t               cfg_r;
  logic [XW-1:0]      x_r, x_nxt;
  logic [YW-1:0]      y_r, y_nxt;
  logic [RXW-1:0]     rx_cur_r, rx_cur_nxt;
  logic [RXW-1:0]     rx_prev_r, rx_prev_nxt;
  logic [XW-1:0]      rx_acc_r, rx_acc_nxt;
  logic [RYW-1:0]     ry_cur_r, ry_cur_nxt;
  logic [RYW-1:0]     ry_prev_r, ry_prev_nxt;
  logic [YW-1:0]      ry_acc_r, ry_acc_nxt;
  logic               is_read_r, is_read_nxt;
  logic               hit_r, hit_nxt;
  logic [IDX_W-1:0]   idx_r, idx_nxt;
  logic [PIXEL_W-1:0] pix_r, pix_nxt;
  logic [PIXEL_W-1:0] prev_pix_r, prev_pix_nxt;
  logic [PIXEL_W-1:0] above_r, above_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [COUNT_W-1:0] out_count_r, out_count_nxt;

  // memory ports
  logic               row_we, row_re;
  logic [XW-1:0]      row_raddr;
  logic [PIXEL_W-1:0] row_rdata;
  logic               h_we, h_re;
  logic [IDX_W-1:0]   h_waddr;
  logic [COUNT_W-1:0] h_wdata, h_rdata;

  // control
  logic               out_free;
  logic               in_accept;
  logic               finish;
  logic               job_step;
  logic               load_out;

  // tally job
  logic               job_en;
  diff_t              job_gx, job_gy;
  logic [RXW-1:0]     job_rx;
  logic [RYW-1:0]     job_ry;
  logic [BIN_W-1:0]   job_bin;
  logic [IDX_W-1:0]   job_idx;
  logic [IDX_W-1:0]   read_idx;
  logic               read_hit;
  logic [XW:0]        rx_sum;
  logic [YW:0]        ry_sum;

  ghg_ram #(
    .WIDTH (PIXEL_W),
    .DEPTH (IMAGE_WIDTH)
  ) u_row_ram (
    .clk   (clk),
    .we    (row_we),
    .waddr (x_r),
    .wdata (pix_r),
    .re    (row_re),
    .raddr (row_raddr),
    .rdata (row_rdata)
  );

  ghg_ram #(
    .WIDTH (COUNT_W),
    .DEPTH (DEPTH)
  ) u_count_ram (
    .clk   (clk),
    .we    (h_we),
    .waddr (h_waddr),
    .wdata (h_wdata),
    .re    (h_re),
    .raddr (idx_r),
    .rdata (h_rdata)
  );

  ghg_classify u_classify (
    .cfg (cfg_r),
    .gx  (job_gx),
    .gy  (job_gy),
    .bin (job_bin)
  );

  assign out_free  = !out_valid_r || !out_stall;
  assign in_accept = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_count = out_count_r;

  // tally selection; the row RAM output still holds the above-right pixel
  always_comb begin
    job_en = 1'b0;
    job_gx = '0;
    job_gy = '0;
    job_rx = rx_cur_r;
    job_ry = ry_cur_r;
    case (jsel_r)
      JOB_ABOVE: begin
        job_en = (y_r != '0);
        job_gx = (x_r != X_LAST) ? pixel_diff(row_rdata, above_r) : '0;
        job_gy = pixel_diff(pix_r, above_r);
        job_ry = ry_prev_r;
      end
      JOB_LEFT: begin
        job_en = (y_r == Y_LAST) && (x_r != '0);
        job_gx = pixel_diff(pix_r, prev_pix_r);
        job_rx = rx_prev_r;
      end
      JOB_CORNER: begin
        job_en = (y_r == Y_LAST) && (x_r == X_LAST);
      end
      default: begin
        job_en = 1'b0;
      end
    endcase
    job_idx = (IDX_W'(job_ry) * IDX_COLS + IDX_W'(job_rx)) * IDX_BINS
              + IDX_W'(job_bin);
    read_idx = IDX_W'(in_region) * IDX_BINS + IDX_W'(in_bin);
    read_hit = ({5'b0, in_region} < REGION_LIMIT) && (in_bin < BIN_LIMIT);
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (clr_cnt_r == IDX_LAST) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = (in_kind == KIND_READ) ? ST_HRD : ST_ROW;
        end
      end
      ST_ROW: begin
        state_nxt = ST_JOB;
      end
      ST_JOB: begin
        if (job_en) begin
          state_nxt = ST_HRD;
        end else if (jsel_r == JOB_CORNER) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_HRD: begin
        state_nxt = ST_HWR;
      end
      ST_HWR: begin
        if (is_read_r) begin
          if (out_free) begin
            state_nxt = ST_IDLE;
          end
        end else begin
          state_nxt = (jsel_r == JOB_CORNER) ? ST_IDLE : ST_JOB;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control outputs
  always_comb begin
    in_stall  = 1'b1;
    row_we    = 1'b0;
    row_re    = 1'b0;
    row_raddr = x_r;
    h_we      = 1'b0;
    h_re      = 1'b0;
    h_waddr   = idx_r;
    h_wdata   = '0;
    finish    = 1'b0;
    job_step  = 1'b0;
    load_out  = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        h_we    = 1'b1;
        h_waddr = clr_cnt_r;
      end
      ST_IDLE: begin
        in_stall = 1'b0;
        row_re   = in_valid && (in_kind == KIND_PIXEL);
      end
      ST_ROW: begin
        // above pixel arrives now; fetch above-right, store this pixel
        row_re    = 1'b1;
        row_raddr = XW'(x_r + 1'b1);
        row_we    = 1'b1;
      end
      ST_JOB: begin
        if (!job_en) begin
          finish   = (jsel_r == JOB_CORNER);
          job_step = (jsel_r != JOB_CORNER);
        end
      end
      ST_HRD: begin
        h_re = hit_r;
      end
      ST_HWR: begin
        if (is_read_r) begin
          load_out = out_free;
          h_we     = hit_r && out_free;
        end else begin
          h_we     = 1'b1;
          h_wdata  = (h_rdata == COUNT_MAX) ? h_rdata : h_rdata + COUNT_W'(1);
          finish   = (jsel_r == JOB_CORNER);
          job_step = (jsel_r != JOB_CORNER);
        end
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  // datapath next values
  always_comb begin
    clr_cnt_nxt   = (state_r == ST_CLEAR) ? clr_cnt_r + IDX_W'(1) : clr_cnt_r;
    jsel_nxt      = jsel_r;
    is_read_nxt   = is_read_r;
    hit_nxt       = hit_r;
    idx_nxt       = idx_r;
    pix_nxt       = pix_r;
    above_nxt     = above_r;
    prev_pix_nxt  = prev_pix_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    rx_cur_nxt    = rx_cur_r;
    rx_prev_nxt   = rx_prev_r;
    rx_acc_nxt    = rx_acc_r;
    ry_cur_nxt    = ry_cur_r;
    ry_prev_nxt   = ry_prev_r;
    ry_acc_nxt    = ry_acc_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_count_nxt = out_count_r;
    rx_sum        = {1'b0, rx_acc_r} + RX_FRAC;
    ry_sum        = {1'b0, ry_acc_r} + RY_FRAC;

    if (in_accept) begin
      is_read_nxt = (in_kind == KIND_READ);
      pix_nxt     = in_pixel;
      hit_nxt     = read_hit;
      idx_nxt     = read_idx;
    end

    if (state_r == ST_ROW) begin
      above_nxt = row_rdata;
      jsel_nxt  = JOB_ABOVE;
    end

    if (state_r == ST_JOB && job_en) begin
      hit_nxt = 1'b1;
      idx_nxt = job_idx;
    end

    if (job_step) begin
      jsel_nxt = job_t'(jsel_r + 2'd1);
    end

    if (load_out) begin
      out_valid_nxt = 1'b1;
      out_count_nxt = hit_r ? h_rdata : '0;
    end

    if (finish) begin
      prev_pix_nxt = pix_r;
      rx_prev_nxt  = rx_cur_r;
      if (x_r == X_LAST) begin
        x_nxt      = '0;
        rx_cur_nxt = '0;
        rx_acc_nxt = '0;
        if (y_r == Y_LAST) begin
          y_nxt      = '0;
          ry_cur_nxt = '0;
          ry_acc_nxt = '0;
        end else begin
          y_nxt       = y_r + YW'(1);
          ry_prev_nxt = ry_cur_r;
          if (ry_sum >= Y_SPAN) begin
            ry_acc_nxt = YW'(ry_sum - Y_SPAN);
            ry_cur_nxt = ry_cur_r + RY_WHOLE + RYW'(1);
          end else begin
            ry_acc_nxt = YW'(ry_sum);
            ry_cur_nxt = ry_cur_r + RY_WHOLE;
          end
        end
      end else begin
        x_nxt = x_r + XW'(1);
        if (rx_sum >= X_SPAN) begin
          rx_acc_nxt = XW'(rx_sum - X_SPAN);
          rx_cur_nxt = rx_cur_r + RX_WHOLE + RXW'(1);
        end else begin
          rx_acc_nxt = XW'(rx_sum);
          rx_cur_nxt = rx_cur_r + RX_WHOLE;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      jsel_r      <= JOB_ABOVE;
      clr_cnt_r   <= '0;
      x_r         <= '0;
      y_r         <= '0;
      rx_cur_r    <= '0;
      rx_prev_r   <= '0;
      rx_acc_r    <= '0;
      ry_cur_r    <= '0;
      ry_prev_r   <= '0;
      ry_acc_r    <= '0;
      is_read_r   <= 1'b0;
      hit_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      jsel_r      <= jsel_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      x_r         <= x_nxt;
      y_r         <= y_nxt;
      rx_cur_r    <= rx_cur_nxt;
      rx_prev_r   <= rx_prev_nxt;
      rx_acc_r    <= rx_acc_nxt;
      ry_cur_r    <= ry_cur_nxt;
      ry_prev_r   <= ry_prev_nxt;
      ry_acc_r    <= ry_acc_nxt;
      is_read_r   <= is_read_nxt;
      hit_r       <= hit_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r       <= idx_nxt;
    pix_r       <= pix_nxt;
    prev_pix_r  <= prev_pix_nxt;
    above_r     <= above_nxt;
    out_count_r <= out_count_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.dir_threshold <= DIR_THRESHOLD_RST;
      cfg_r.edge_one      <= EDGE_ONE_RST;
      cfg_r.edge_two      <= EDGE_TWO_RST;
      cfg_r.edge_three    <= EDGE_THREE_RST;
      cfg_r.edge_four     <= EDGE_FOUR_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DIR_THRESHOLD: cfg_r.dir_threshold <= cfg_data[THRESH_W-1:0];
        CFG_EDGE_ONE:      cfg_r.edge_one      <= cfg_data[EDGE_W-1:0];
        CFG_EDGE_TWO:      cfg_r.edge_two      <= cfg_data[EDGE_W-1:0];
        CFG_EDGE_THREE:    cfg_r.edge_three    <= cfg_data[EDGE_W-1:0];
        CFG_EDGE_FOUR:     cfg_r.edge_four     <= cfg_data[EDGE_W-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire
